>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, entry type, request and status codes shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int unsigned TAG_BITS      = 16;
  localparam int unsigned CNT_W         = $clog2(DEPTH + 1);

  localparam int unsigned IN_DATA_W  = ((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = PRIORITY_BITS + TAG_BITS + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occupied_i,
  input  wire logic                left_greater_i,
  input  wire spq_pkg::entry_t     left_entry_i,
  input  wire spq_pkg::entry_t     right_entry_i,
  output      logic                greater_o,
  output      spq_pkg::entry_t     entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // stays ahead of the new entry: equal priorities keep arrival order
  assign greater_o = occupied_i && (entry_q.prio >= ctrl_i.new_entry.prio);
  assign entry_o   = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!greater_o) begin
        if (left_greater_i) begin
          entry_d = ctrl_i.new_entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of tagged entries held in descending priority order.
// ----------------------------------------------------------------------------
// Each beat on the slave side is an insert (tuser 0) or a pop (tuser 1) and
// gives exactly one result beat. The entries sit in a row of cells, head
// first; every cell compares its priority with the incoming one in parallel
// and shifts right on insert or left on pop; a new beat is accepted every
// cycle while the result register is empty or being drained. An insert goes
// behind all entries of greater or equal priority. A full insert returns
// status 1, an empty pop status 2; neither changes the queue. Popped priority
// and tag are zero on all other results.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // in_priority, in_tag
  input  wire logic [spq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  wire logic                             s_axis_tuser,
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_priority, out_tag, fill_count, zero pad
  output      logic [spq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output      logic [1:0]                       m_axis_tuser
);
  import spq_pkg::*;

  logic             accept;
  logic             full;
  logic             empty;
  req_e             req;
  entry_t           in_entry;
  cell_ctrl_t       ctrl;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  entry_t           out_entry_q, out_entry_d;
  logic [CNT_W-1:0] out_fill_q;

  logic   [DEPTH-1:0] greater;
  logic   [DEPTH-1:0] occupied;
  entry_t [DEPTH-1:0] cell_entry;

  assign req      = req_e'(s_axis_tuser);
  assign in_entry = '{prio: s_axis_tdata[PRIORITY_BITS-1:0],
                      tag:  s_axis_tdata[PRIORITY_BITS+TAG_BITS-1:PRIORITY_BITS]};

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(DEPTH));
  assign empty         = (count_q == '0);

  assign ctrl.ins       = accept && (req == REQ_INSERT) && !full;
  assign ctrl.pop       = accept && (req == REQ_POP) && !empty;
  assign ctrl.new_entry = in_entry;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_greater;

    assign occupied[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_entry   = '0;
      assign left_greater = 1'b1;
    end else begin : g_body
      assign left_entry   = cell_entry[i-1];
      assign left_greater = greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occupied_i     (occupied[i]),
      .left_greater_i (left_greater),
      .left_entry_i   (left_entry),
      .right_entry_i  (right_entry),
      .greater_o      (greater[i]),
      .entry_o        (cell_entry[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    out_entry_d = out_entry_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      out_entry_d = '0;
      status_d    = ST_DONE;
      if (req == REQ_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d     = count_q - CNT_W'(1);
          out_entry_d = cell_entry[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_entry_q <= out_entry_d;
      out_fill_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_fill_q, out_entry_q.tag, out_entry_q.prio});

endmodule

`default_nettype wire

>>> dv/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends insert and pop beats through the slave stream and checks every result
// beat against a behavioural queue held here: priority order, arrival order
// among equal priorities, full and empty refusals, and the fill count. Both
// stream sides idle in random bursts, except in the closing phase.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_e                  status;
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
    logic [CNT_W-1:0]         fill;
  } queue_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  logic [PRIORITY_BITS-1:0] queue_prio [DEPTH];
  logic [TAG_BITS-1:0]      queue_tag  [DEPTH];
  int unsigned              queue_fill = 0;
  queue_result_t            pending_results [$];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          quiet_phase = 1'b0;

  sorted_priority_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Updates the local queue for one accepted request and records its result.
  task automatic apply_request(req_e req, logic [PRIORITY_BITS-1:0] prio,
                               logic [TAG_BITS-1:0] tag);
    queue_result_t res;
    int unsigned   pos;
    res = '{status: ST_DONE, prio: '0, tag: '0, fill: '0};
    if (req == REQ_INSERT) begin
      if (queue_fill >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < queue_fill && queue_prio[pos] >= prio) pos++;
        for (int unsigned i = queue_fill; i > pos; i--) begin
          queue_prio[i] = queue_prio[i-1];
          queue_tag[i]  = queue_tag[i-1];
        end
        queue_prio[pos] = prio;
        queue_tag[pos]  = tag;
        queue_fill++;
      end
    end else begin
      if (queue_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.prio = queue_prio[0];
        res.tag  = queue_tag[0];
        for (int unsigned i = 1; i < queue_fill; i++) begin
          queue_prio[i-1] = queue_prio[i];
          queue_tag[i-1]  = queue_tag[i];
        end
        queue_fill--;
      end
    end
    res.fill = CNT_W'(queue_fill);
    pending_results.push_back(res);
  endtask

  task automatic send_req(req_e req, logic [PRIORITY_BITS-1:0] prio,
                          logic [TAG_BITS-1:0] tag);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, prio};
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_request(req, prio, tag);
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_pop();
    send_req(REQ_POP, 8'hff, 16'hffff);
  endtask

  task automatic test_order_and_ties();
    send_req(REQ_INSERT, 8'h00, 16'h0000);
    send_req(REQ_INSERT, 8'hff, 16'hffff);
    send_req(REQ_INSERT, 8'h55, 16'h0001);
    send_req(REQ_INSERT, 8'h55, 16'h0002);
    send_req(REQ_INSERT, 8'h55, 16'h0003);
    send_req(REQ_POP, 8'h00, 16'h0000);
    send_req(REQ_POP, 8'h00, 16'h0000);
  endtask

  task automatic test_full_insert();
    for (int i = 0; i < 13; i++) begin
      send_req(REQ_INSERT, (i % 4 == 0) ? 8'h55 : 8'(i * 37), 16'(16'h1000 + i));
    end
    send_req(REQ_INSERT, 8'hff, 16'hffff);
    send_req(REQ_INSERT, 8'h00, 16'haaaa);
  endtask

  // insert_pct sets the insert share; narrow picks priorities from four values
  task automatic test_random_mix(int unsigned beats, int unsigned insert_pct, bit narrow);
    logic [PRIORITY_BITS-1:0] prio;
    req_e                     req;
    for (int unsigned n = 0; n < beats; n++) begin
      prio = narrow ? PRIORITY_BITS'($urandom_range(0, 3) * 85)
                    : PRIORITY_BITS'($urandom);
      req  = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
      send_req(req, prio, TAG_BITS'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    queue_result_t exp_res;
    queue_result_t got_res;
    if (m_axis_tvalid && m_axis_tready) begin
      got_res.status = status_e'(m_axis_tuser);
      got_res.prio   = m_axis_tdata[0 +: PRIORITY_BITS];
      got_res.tag    = m_axis_tdata[PRIORITY_BITS +: TAG_BITS];
      got_res.fill   = m_axis_tdata[PRIORITY_BITS+TAG_BITS +: CNT_W];
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result beat: %p", got_res);
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res !== exp_res) begin
          err_count++;
          if (err_count <= 10) $display("mismatch: expected %p, got %p", exp_res, got_res);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pop();
    test_order_and_ties();
    test_full_insert();
    test_random_mix(100, 25, 1'b0);
    test_random_mix(100, 75, 1'b0);
    test_random_mix(60, 50, 1'b1);
    drain_wait();
    test_random_mix(60, 90, 1'b1);
    test_random_mix(60, 10, 1'b0);
    quiet_phase = 1'b1;
    test_random_mix(100, 55, 1'b1);

    drain_wait();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
